// ===== rtl/core/bcsc_pkg.sv =====
`timescale 1ns / 1ps

package bcsc_pkg;

    // per-stage status that travels with each item down the chain
    typedef struct packed {
        logic valid;
        logic hit;
    } t_stat;

    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int CHORD_OUT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TAN_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_MAX = 1'b1;

    localparam logic [CFG_W-1:0] TAN_MIN_RST = 15'd880;
    localparam logic [CFG_W-1:0] TAN_MAX_RST = 15'd2880;

endpackage

// ===== rtl/core/bcsc_in_if.sv =====
`timescale 1ns / 1ps

interface bcsc_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] curve_from_x;
    logic signed [COORD_BITS-1:0] curve_from_y;
    logic signed [COORD_BITS-1:0] curve_to_x;
    logic signed [COORD_BITS-1:0] curve_to_y;
    logic signed [COORD_BITS-1:0] knife_start_x;
    logic signed [COORD_BITS-1:0] knife_start_y;
    logic signed [COORD_BITS-1:0] knife_end_x;
    logic signed [COORD_BITS-1:0] knife_end_y;

    modport source (
        output valid, curve_from_x, curve_from_y, curve_to_x, curve_to_y,
               knife_start_x, knife_start_y, knife_end_x, knife_end_y,
        input  ready
    );
    modport sink (
        input  valid, curve_from_x, curve_from_y, curve_to_x, curve_to_y,
               knife_start_x, knife_start_y, knife_end_x, knife_end_y,
        output ready
    );
endinterface

// ===== rtl/core/bcsc_out_if.sv =====
`timescale 1ns / 1ps

interface bcsc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic [bcsc_pkg::CHORD_OUT_W-1:0]     crossing_chord;

    modport source (output valid, hit, crossing_chord, input ready);
    modport sink   (input valid, hit, crossing_chord, output ready);
endinterface

// ===== rtl/core/bcsc_front.sv =====
`timescale 1ns / 1ps

// Entry stage: tangent clamp, control points, point 0 and scaled knife.
module bcsc_front #(
    parameter  int CHORDS     = 32,
    parameter  int COORD_BITS = 16,
    localparam int CB   = COORD_BITS,
    localparam int TW   = (CB + 1 > 16) ? CB + 1 : 16,
    localparam int PW   = TW + 2,
    localparam int CUBE = CHORDS * CHORDS * CHORDS,
    localparam int PTW  = PW + $clog2(CUBE) + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bcsc_pkg::CFG_W-1:0]    i_tan_min,
    input  logic [bcsc_pkg::CFG_W-1:0]    i_tan_max,
    input  logic signed [CB-1:0]          i_pt [0:7],
    output bcsc_pkg::t_stat               o_stat,
    output logic signed [PW-1:0]          o_ctl [0:7],
    output logic signed [PTW-1:0]         o_knf [0:3],
    output logic signed [PTW-1:0]         o_prev [0:1]
);
    localparam logic signed [PTW-1:0] K_CUBE  = PTW'(CUBE);
    localparam logic signed [PTW-1:0] K_SCALE = PTW'(2 * CUBE);

    logic signed [CB:0]    dx;
    logic        [CB:0]    mag;
    logic        [TW-1:0]  mag_e, lo, hi, tan_lo, tan2;
    logic signed [PW-1:0]  tan_s;
    logic signed [PW-1:0]  n_ctl [0:7];

    logic                  r_valid;
    logic signed [PW-1:0]  r_ctl [0:7];
    logic signed [PTW-1:0] r_knf [0:3];
    logic signed [PTW-1:0] r_prev [0:1];

    always_comb begin
        dx     = (CB+1)'(i_pt[2]) - (CB+1)'(i_pt[0]);
        mag    = dx[CB] ? (CB+1)'(-dx) : dx;
        mag_e  = TW'(mag);
        lo     = TW'({i_tan_min, 1'b0});
        hi     = TW'({i_tan_max, 1'b0});
        tan_lo = (mag_e < lo) ? lo : mag_e;
        tan2   = (tan_lo > hi) ? hi : tan_lo;
        tan_s  = PW'(signed'({1'b0, tan2}));
        n_ctl[0] = PW'(i_pt[0]) <<< 1;
        n_ctl[1] = PW'(i_pt[1]) <<< 1;
        n_ctl[2] = (PW'(i_pt[0]) <<< 1) + tan_s;
        n_ctl[3] = PW'(i_pt[1]) <<< 1;
        n_ctl[4] = (PW'(i_pt[2]) <<< 1) - tan_s;
        n_ctl[5] = PW'(i_pt[3]) <<< 1;
        n_ctl[6] = PW'(i_pt[2]) <<< 1;
        n_ctl[7] = PW'(i_pt[3]) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 8; j++) r_ctl[j] <= n_ctl[j];
            for (int j = 0; j < 4; j++) r_knf[j] <= PTW'(i_pt[4+j]) * K_SCALE;
            r_prev[0] <= PTW'(n_ctl[0]) * K_CUBE;
            r_prev[1] <= PTW'(n_ctl[1]) * K_CUBE;
        end
    end

    assign o_stat = '{valid: r_valid, hit: 1'b0};
    assign o_ctl  = r_ctl;
    assign o_knf  = r_knf;
    assign o_prev = r_prev;
endmodule

// ===== rtl/core/bcsc_cell.sv =====
`timescale 1ns / 1ps

// One chord: point IDX+1, differences, six cross terms, crossing decision.
module bcsc_cell #(
    parameter  int CHORDS     = 32,
    parameter  int COORD_BITS = 16,
    parameter  int IDX        = 0,
    localparam int CB   = COORD_BITS,
    localparam int TW   = (CB + 1 > 16) ? CB + 1 : 16,
    localparam int PW   = TW + 2,
    localparam int CUBE = CHORDS * CHORDS * CHORDS,
    localparam int PTW  = PW + $clog2(CUBE) + 1,
    localparam int DW   = PTW + 1,
    localparam int CW   = 2 * DW + 1,
    localparam int IW   = $clog2(CHORDS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  bcsc_pkg::t_stat       i_stat,
    input  logic [IW-1:0]         i_idx,
    input  logic signed [PW-1:0]  i_ctl [0:7],
    input  logic signed [PTW-1:0] i_knf [0:3],
    input  logic signed [PTW-1:0] i_prev [0:1],
    output bcsc_pkg::t_stat       o_stat,
    output logic [IW-1:0]         o_idx,
    output logic signed [PW-1:0]  o_ctl [0:7],
    output logic signed [PTW-1:0] o_knf [0:3],
    output logic signed [PTW-1:0] o_prev [0:1]
);
    localparam int TI = IDX + 1;
    localparam int TU = CHORDS - TI;
    localparam logic signed [PTW-1:0] W0 = PTW'(TU * TU * TU);
    localparam logic signed [PTW-1:0] W1 = PTW'(3 * TU * TU * TI);
    localparam logic signed [PTW-1:0] W2 = PTW'(3 * TU * TI * TI);
    localparam logic signed [PTW-1:0] W3 = PTW'(TI * TI * TI);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    // stage 1: curve point
    bcsc_pkg::t_stat       r1_stat;
    logic [IW-1:0]         r1_idx;
    logic signed [PW-1:0]  r1_ctl [0:7];
    logic signed [PTW-1:0] r1_knf [0:3];
    logic signed [PTW-1:0] r1_prev [0:1];
    logic signed [PTW-1:0] r1_cur [0:1];
    // stage 2: differences
    bcsc_pkg::t_stat       r2_stat;
    logic [IW-1:0]         r2_idx;
    logic signed [PW-1:0]  r2_ctl [0:7];
    logic signed [PTW-1:0] r2_knf [0:3];
    logic signed [PTW-1:0] r2_cur [0:1];
    logic signed [DW-1:0]  r2_f [0:1];
    logic signed [DW-1:0]  r2_s [0:1];
    logic signed [DW-1:0]  r2_o [0:1];
    // stage 3: cross terms
    bcsc_pkg::t_stat       r3_stat;
    logic [IW-1:0]         r3_idx;
    logic signed [PW-1:0]  r3_ctl [0:7];
    logic signed [PTW-1:0] r3_knf [0:3];
    logic signed [PTW-1:0] r3_cur [0:1];
    logic signed [CW-1:0]  r3_m [0:5];
    // stage 4: decision
    bcsc_pkg::t_stat       r4_stat;
    logic [IW-1:0]         r4_idx;
    logic signed [PW-1:0]  r4_ctl [0:7];
    logic signed [PTW-1:0] r4_knf [0:3];
    logic signed [PTW-1:0] r4_cur [0:1];

    logic signed [CW-1:0]  den, n1, n2;
    logic                  cross_ok;
    bcsc_pkg::t_stat       n_stat;
    logic [IW-1:0]         n_idx;

    always_comb begin
        den = r3_m[0] - r3_m[1];
        n1  = r3_m[2] - r3_m[3];
        n2  = r3_m[4] - r3_m[5];
        // sign of den picks the window; inclusive at both ends
        if (den > 0) begin
            cross_ok = (n1 >= 0) && (n1 <= den) && (n2 >= 0) && (n2 <= den);
        end else if (den < 0) begin
            cross_ok = (n1 <= 0) && (n1 >= den) && (n2 <= 0) && (n2 >= den);
        end else begin
            cross_ok = 1'b0;
        end
        n_stat.valid = r3_stat.valid;
        n_stat.hit   = r3_stat.hit | cross_ok;
        n_idx        = (r3_stat.hit || !cross_ok) ? r3_idx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_stat <= '0;
            r2_stat <= '0;
            r3_stat <= '0;
            r4_stat <= '0;
        end else if (i_en) begin
            r1_stat <= i_stat;
            r2_stat <= r1_stat;
            r3_stat <= r2_stat;
            r4_stat <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_idx  <= i_idx;
            r1_ctl  <= i_ctl;
            r1_knf  <= i_knf;
            r1_prev <= i_prev;
            for (int k = 0; k < 2; k++) begin
                r1_cur[k] <= PTW'(i_ctl[k]) * W0 + PTW'(i_ctl[2+k]) * W1
                           + PTW'(i_ctl[4+k]) * W2 + PTW'(i_ctl[6+k]) * W3;
            end

            r2_idx <= r1_idx;
            r2_ctl <= r1_ctl;
            r2_knf <= r1_knf;
            r2_cur <= r1_cur;
            for (int k = 0; k < 2; k++) begin
                r2_f[k] <= DW'(r1_knf[2+k]) - DW'(r1_knf[k]);
                r2_s[k] <= DW'(r1_cur[k]) - DW'(r1_prev[k]);
                r2_o[k] <= DW'(r1_prev[k]) - DW'(r1_knf[k]);
            end

            r3_idx <= r2_idx;
            r3_ctl <= r2_ctl;
            r3_knf <= r2_knf;
            r3_cur <= r2_cur;
            r3_m[0] <= CW'(r2_f[0]) * CW'(r2_s[1]);
            r3_m[1] <= CW'(r2_f[1]) * CW'(r2_s[0]);
            r3_m[2] <= CW'(r2_o[0]) * CW'(r2_s[1]);
            r3_m[3] <= CW'(r2_o[1]) * CW'(r2_s[0]);
            r3_m[4] <= CW'(r2_o[0]) * CW'(r2_f[1]);
            r3_m[5] <= CW'(r2_o[1]) * CW'(r2_f[0]);

            r4_idx <= n_idx;
            r4_ctl <= r3_ctl;
            r4_knf <= r3_knf;
            r4_cur <= r3_cur;
        end
    end

    assign o_stat = r4_stat;
    assign o_idx  = r4_idx;
    assign o_ctl  = r4_ctl;
    assign o_knf  = r4_knf;
    assign o_prev = r4_cur;
endmodule

// ===== rtl/core/bezier_curve_segment_cut_test.sv =====
`timescale 1ns / 1ps
// An item passes the front register, the stage registers of every chord cell, then the result register.
// Throughput: one item per cycle while the skid entry is free; the chord-cell chain is fully pipelined.
// A two-entry output buffer (result register plus skid) lets the chain run while
// a result waits; input ready drops only once the skid entry is occupied.
// Reset (sync, active low): pipeline valid bits and buffer cleared, tangent
// limits return to 880 and 2880.
module bezier_curve_segment_cut_test #(
    parameter int CHORDS     = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bcsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bcsc_pkg::CFG_W-1:0]          i_cfg_data,
    bcsc_in_if.sink                             i_item,
    bcsc_out_if.source                          o_res
);
    localparam int CB   = COORD_BITS;
    localparam int TW   = (CB + 1 > 16) ? CB + 1 : 16;
    localparam int PW   = TW + 2;
    localparam int CUBE = CHORDS * CHORDS * CHORDS;
    localparam int PTW  = PW + $clog2(CUBE) + 1;
    localparam int IW   = $clog2(CHORDS);

    // configuration registers
    logic [bcsc_pkg::CFG_W-1:0] r_tan_min, r_tan_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tan_min <= bcsc_pkg::TAN_MIN_RST;
            r_tan_max <= bcsc_pkg::TAN_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcsc_pkg::CFG_TAN_MIN: r_tan_min <= i_cfg_data;
                bcsc_pkg::CFG_TAN_MAX: r_tan_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // chain advances whenever the skid entry is free
    logic r_skid_v;
    logic en;
    assign en = !r_skid_v;
    assign i_item.ready = en;

    logic signed [CB-1:0] in_pt [0:7];
    assign in_pt[0] = i_item.curve_from_x;
    assign in_pt[1] = i_item.curve_from_y;
    assign in_pt[2] = i_item.curve_to_x;
    assign in_pt[3] = i_item.curve_to_y;
    assign in_pt[4] = i_item.knife_start_x;
    assign in_pt[5] = i_item.knife_start_y;
    assign in_pt[6] = i_item.knife_end_x;
    assign in_pt[7] = i_item.knife_end_y;

    // links between cells; link k feeds cell k
    bcsc_pkg::t_stat       lk_stat [0:CHORDS];
    logic [IW-1:0]         lk_idx  [0:CHORDS];
    logic signed [PW-1:0]  lk_ctl  [0:CHORDS][0:7];
    logic signed [PTW-1:0] lk_knf  [0:CHORDS][0:3];
    logic signed [PTW-1:0] lk_prev [0:CHORDS][0:1];

    bcsc_front #(.CHORDS(CHORDS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_item.valid),
        .i_tan_min (r_tan_min),
        .i_tan_max (r_tan_max),
        .i_pt      (in_pt),
        .o_stat    (lk_stat[0]),
        .o_ctl     (lk_ctl[0]),
        .o_knf     (lk_knf[0]),
        .o_prev    (lk_prev[0])
    );
    assign lk_idx[0] = '0;

    for (genvar k = 0; k < CHORDS; k++) begin : g_cell
        bcsc_cell #(.CHORDS(CHORDS), .COORD_BITS(COORD_BITS), .IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stat  (lk_stat[k]),
            .i_idx   (lk_idx[k]),
            .i_ctl   (lk_ctl[k]),
            .i_knf   (lk_knf[k]),
            .i_prev  (lk_prev[k]),
            .o_stat  (lk_stat[k+1]),
            .o_idx   (lk_idx[k+1]),
            .o_ctl   (lk_ctl[k+1]),
            .o_knf   (lk_knf[k+1]),
            .o_prev  (lk_prev[k+1])
        );
    end

    // result register plus skid entry
    logic                               push;
    logic                               r_out_v, r_out_hit, r_skid_hit;
    logic [bcsc_pkg::CHORD_OUT_W-1:0]   r_out_chord, r_skid_chord, last_chord;

    assign push       = en && lk_stat[CHORDS].valid;
    assign last_chord = bcsc_pkg::CHORD_OUT_W'(lk_idx[CHORDS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            priority if (r_out_v && o_res.ready) begin
                if (r_skid_v) begin
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= push;
                end
            end else if (!r_out_v) begin
                r_out_v <= push;
            end else begin
                if (push) r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_out_v && o_res.ready && r_skid_v) begin
            r_out_hit   <= r_skid_hit;
            r_out_chord <= r_skid_chord;
        end else if (!r_out_v || o_res.ready) begin
            r_out_hit   <= lk_stat[CHORDS].hit;
            r_out_chord <= last_chord;
        end else begin
            if (push) begin
                r_skid_hit   <= lk_stat[CHORDS].hit;
                r_skid_chord <= last_chord;
            end
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.hit            = r_out_hit;
    assign o_res.crossing_chord = r_out_chord;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    localparam int CHORDS     = 32;
    localparam int COORD_BITS = 16;
    localparam int SCALE      = 2 * CHORDS * CHORDS * CHORDS;
    localparam int LATENCY    = 4 * CHORDS + 2;
    localparam int SETTLE     = LATENCY + 10;   // cycles to let the chain run dry
    localparam int STALL_PCT  = 28;
    localparam int WDOG_LIMIT = 5000;           // cycles with no accept at all
    localparam int N_PHASE    = 6;
    localparam int PHASE_LEN  = 290;            // random items per config setting

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // field order: curve from x/y, curve to x/y, knife start x/y, knife end x/y
    typedef struct {
        t_coord c [8];
    } t_cut_item;

    typedef struct {
        bit       hit;
        bit [4:0] chord;
    } t_cut_res;

    typedef struct {
        t_cut_item item;
        bit        typed;   // expected value written by hand
        t_cut_res  res;
    } t_cut_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [bcsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [bcsc_pkg::CFG_W-1:0]         i_cfg_data;

    bcsc_in_if #(.COORD_BITS(COORD_BITS)) item_ch ();
    bcsc_out_if                           res_ch ();

    bezier_curve_segment_cut_test #(
        .CHORDS    (CHORDS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_item    (item_ch),
        .o_res     (res_ch)
    );

    // mirror of the tangent clamp registers
    int unsigned tan_lo_q;
    int unsigned tan_hi_q;

    t_cut_res expected_cuts [$];
    t_cut_row rows [$];
    int       n_errors;
    bit       gaps_on;   // both sides idle at random while set
    int       quiet_cnt;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor: exact scaled flattening and crossing test
    // ------------------------------------------------------------------
    function automatic logic signed [127:0] cross2(longint px, longint py,
                                                   longint qx, longint qy);
        logic signed [127:0] a, b, c, d;
        a = px; b = py; c = qx; d = qy;
        return a * d - b * c;
    endfunction

    // knife k0->k1 against chord c0->c1, all at the same scale
    function automatic bit chord_cut(longint k0x, longint k0y, longint k1x, longint k1y,
                                     longint c0x, longint c0y, longint c1x, longint c1y);
        logic signed [127:0] den, n1, n2;
        longint fx, fy, sx, sy, ox, oy;
        fx = k1x - k0x; fy = k1y - k0y;
        sx = c1x - c0x; sy = c1y - c0y;
        ox = c0x - k0x; oy = c0y - k0y;
        den = cross2(fx, fy, sx, sy);
        if (den == 0) return 1'b0;          // parallel or degenerate
        n1 = cross2(ox, oy, sx, sy);
        n2 = cross2(ox, oy, fx, fy);
        if (den < 0) begin
            den = -den; n1 = -n1; n2 = -n2;
        end
        // inclusive at both ends: touching counts
        return n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den;
    endfunction

    function automatic t_cut_res predict_cut(t_cut_item it);
        t_cut_res r;
        longint fx, fy, tx, ty, mag, lo, hi, tan2;
        longint px [4], py [4], qx [CHORDS+1], qy [CHORDS+1];
        longint ks [4];
        longint u, w0, w1, w2, w3;
        fx = longint'(it.c[0]); fy = longint'(it.c[1]);
        tx = longint'(it.c[2]); ty = longint'(it.c[3]);
        mag = tx - fx;
        if (mag < 0) mag = -mag;
        lo = 2 * longint'(tan_lo_q);
        hi = 2 * longint'(tan_hi_q);
        tan2 = (mag < lo) ? lo : mag;
        if (tan2 > hi) tan2 = hi;             // inverted bounds end at the max
        px[0] = 2 * fx;        py[0] = 2 * fy;
        px[1] = 2 * fx + tan2; py[1] = 2 * fy;
        px[2] = 2 * tx - tan2; py[2] = 2 * ty;
        px[3] = 2 * tx;        py[3] = 2 * ty;
        for (int k = 0; k < 4; k++) ks[k] = longint'(it.c[4+k]) * SCALE;
        for (int i = 0; i <= CHORDS; i++) begin
            u  = CHORDS - i;
            w0 = u * u * u; w1 = 3 * u * u * i; w2 = 3 * u * i * i; w3 = i * i * i;
            qx[i] = w0 * px[0] + w1 * px[1] + w2 * px[2] + w3 * px[3];
            qy[i] = w0 * py[0] + w1 * py[1] + w2 * py[2] + w3 * py[3];
        end
        r.hit = 1'b0;
        r.chord = '0;
        for (int i = 0; i < CHORDS; i++) begin
            if (chord_cut(ks[0], ks[1], ks[2], ks[3], qx[i], qy[i], qx[i+1], qy[i+1])) begin
                r.hit = 1'b1;
                r.chord = i[4:0];
                return r;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic t_coord clip(int v);
        if (v > 32767) return t_coord'(32767);
        if (v < -32768) return t_coord'(-32768);
        return t_coord'(v);
    endfunction

    function automatic t_cut_item mk(int a, int b, int c, int d,
                                     int e, int f, int g, int h);
        t_cut_item it;
        it.c[0] = t_coord'(a); it.c[1] = t_coord'(b);
        it.c[2] = t_coord'(c); it.c[3] = t_coord'(d);
        it.c[4] = t_coord'(e); it.c[5] = t_coord'(f);
        it.c[6] = t_coord'(g); it.c[7] = t_coord'(h);
        return it;
    endfunction

    // mostly knives aimed through the curve's span, some noise and corner shapes
    function automatic t_cut_item random_cut();
        t_cut_item it;
        int span, mx, my, dx, dy, sel;
        sel = rnd(0, 99);
        if (sel < 20) begin
            for (int k = 0; k < 8; k++) it.c[k] = t_coord'($urandom);
            return it;
        end
        span = (rnd(0, 9) == 0) ? 30000 : rnd(50, 6000);
        for (int k = 0; k < 4; k++) it.c[k] = clip(rnd(-span, span));
        mx = (int'(it.c[0]) + int'(it.c[2])) / 2 + rnd(-span / 4, span / 4);
        my = (int'(it.c[1]) + int'(it.c[3])) / 2 + rnd(-span / 4, span / 4);
        dx = rnd(-span, span);
        dy = rnd(-span, span);
        if (sel < 75) begin
            it.c[4] = clip(mx + dx); it.c[5] = clip(my + dy);
            it.c[6] = clip(mx - dx); it.c[7] = clip(my - dy);
        end else if (sel < 82) begin
            // knife from a curve end: touching case
            it.c[4] = it.c[2 * rnd(0, 1)];
            it.c[5] = (it.c[4] == it.c[0]) ? it.c[1] : it.c[3];
            it.c[6] = clip(int'(it.c[4]) + dx); it.c[7] = clip(int'(it.c[5]) + dy);
        end else if (sel < 88) begin
            // zero length knife
            it.c[4] = clip(mx); it.c[5] = clip(my);
            it.c[6] = it.c[4];  it.c[7] = it.c[5];
        end else if (sel < 94) begin
            // flat curve with a knife along it
            it.c[3] = it.c[1];
            it.c[4] = clip(mx); it.c[5] = it.c[1];
            it.c[6] = clip(mx + dx); it.c[7] = it.c[1];
        end else begin
            // short knife, often misses
            it.c[4] = clip(mx); it.c[5] = clip(my);
            it.c[6] = clip(mx + rnd(-8, 8)); it.c[7] = clip(my + rnd(-8, 8));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_cut(t_cut_item it, bit typed, t_cut_res typed_res);
        while (gaps_on && $urandom_range(99) < STALL_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.curve_from_x  <= it.c[0];
        item_ch.curve_from_y  <= it.c[1];
        item_ch.curve_to_x    <= it.c[2];
        item_ch.curve_to_y    <= it.c[3];
        item_ch.knife_start_x <= it.c[4];
        item_ch.knife_start_y <= it.c[5];
        item_ch.knife_end_x   <= it.c[6];
        item_ch.knife_end_y   <= it.c[7];
        do @(posedge i_clk); while (!item_ch.ready);
        expected_cuts.push_back(typed ? typed_res : predict_cut(it));
    endtask

    // wait until every result is back, then let the chain empty
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_cuts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_tangents(int unsigned lo, int unsigned hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bcsc_pkg::CFG_TAN_MIN;
        i_cfg_data <= lo[bcsc_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= bcsc_pkg::CFG_TAN_MAX;
        i_cfg_data <= hi[bcsc_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tan_lo_q = lo;
        tan_hi_q = hi;
    endtask

    task automatic add_row(t_cut_item it, bit typed, bit hit, int chord);
        t_cut_row r;
        r.item = it;
        r.typed = typed;
        r.res.hit = hit;
        r.res.chord = chord[4:0];
        rows.push_back(r);
    endtask

    // result side stalls at random
    always @(posedge i_clk) begin
        res_ch.ready <= !gaps_on || ($urandom_range(99) >= STALL_PCT);
    end

    // result checker
    always @(posedge i_clk) begin
        t_cut_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_cuts.size() == 0) begin
                $display("%0t: unexpected result hit=%0b chord=%0d", $time,
                         res_ch.hit, res_ch.crossing_chord);
                n_errors++;
            end else begin
                want = expected_cuts.pop_front();
                if (res_ch.hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, res_ch.hit);
                    n_errors++;
                end
                if (res_ch.crossing_chord !== want.chord) begin
                    $display("%0t: crossing_chord expected %0d actual %0d", $time,
                             want.chord, res_ch.crossing_chord);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: any accept on either side resets the count
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned lo_set [N_PHASE];
        int unsigned hi_set [N_PHASE];
        t_cut_res    none;
        n_errors  = 0;
        quiet_cnt = 0;
        gaps_on   = 1'b1;
        tan_lo_q  = int'(bcsc_pkg::TAN_MIN_RST);
        tan_hi_q  = int'(bcsc_pkg::TAN_MAX_RST);
        none.hit  = 1'b0;
        none.chord = '0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= bcsc_pkg::CFG_TAN_MIN;
        i_cfg_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.curve_from_x  <= '0;
        item_ch.curve_from_y  <= '0;
        item_ch.curve_to_x    <= '0;
        item_ch.curve_to_y    <= '0;
        item_ch.knife_start_x <= '0;
        item_ch.knife_start_y <= '0;
        item_ch.knife_end_x   <= '0;
        item_ch.knife_end_y   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset tangents; zero-length knives never hit
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1, 0, 0);
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 1, 0, 0);
        add_row(mk(-32768, -32768, 32767, 32767, 0, -32768, 0, 32767), 0, 0, 0);
        add_row(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 0, 0, 0);
        add_row(mk(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768), 0, 0, 0);
        add_row(mk(0, 0, 1600, 0, 800, -100, 800, 100), 0, 0, 0);
        // knife lying along a flat curve: every chord parallel
        add_row(mk(0, 0, 1600, 0, 100, 0, 1500, 0), 1, 0, 0);
        // knife starts on the curve start: touches the first chord
        add_row(mk(0, 0, 1600, 800, 0, 0, 0, -100), 1, 1, 0);
        // knife starts on the curve end: touches the last chord
        add_row(mk(0, 0, 1600, 800, 1600, 800, 1600, 900), 1, 1, 31);
        // far away
        add_row(mk(0, 0, 100, 0, 20000, 20000, 20001, -20000), 1, 0, 0);
        add_row(mk(0, 0, 100, 400, 1500, 200, -1500, 200), 0, 0, 0);
        add_row(mk(500, 0, -500, 400, -3000, 100, 3000, 300), 0, 0, 0);
        add_row(mk(-200, 50, 200, -50, 0, -4000, 0, 4000), 0, 0, 0);
        add_row(mk(21845, -21846, -21846, 21845, 0, 0, 1, 1), 0, 0, 0);
        for (int k = 0; k < 6; k++) begin
            t_cut_item it;
            it = random_cut();
            add_row(it, 0, 0, 0);
        end
        foreach (rows[i]) send_cut(rows[i].item, rows[i].typed, rows[i].res);

        // clamp settings: reset, extremes, inverted bounds, random
        lo_set[0] = int'(bcsc_pkg::TAN_MIN_RST); hi_set[0] = int'(bcsc_pkg::TAN_MAX_RST);
        lo_set[1] = 0;           hi_set[1] = 0;
        lo_set[2] = 32767;       hi_set[2] = 32767;
        lo_set[3] = 0;           hi_set[3] = 32767;
        lo_set[4] = 3000;        hi_set[4] = 100;
        lo_set[5] = $urandom_range(4000); hi_set[5] = $urandom_range(8000);

        for (int p = 0; p < N_PHASE; p++) begin
            if (p != 0) begin
                drain();
                set_tangents(lo_set[p], hi_set[p]);
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                // one gap-free stretch in the middle of the run
                gaps_on = !(p == 2 && n >= 40 && n < 240);
                // hold-off until the pipe is empty, once per phase
                if (n == PHASE_LEN / 2) drain();
                send_cut(random_cut(), 0, none);
            end
        end
        gaps_on = 1'b1;
        drain();

        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
